[rtl/joystick_direction_angle_macros.svh]
// assertion macros shared by the joystick direction angle rtl
`ifndef JOYSTICK_DIRECTION_ANGLE_MACROS_SVH
`define JOYSTICK_DIRECTION_ANGLE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define JDA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define JDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/jda_pkg.sv]
// package: constants, types and arctangent table for the joystick direction angle block
`timescale 1ns / 1ps

package jda_pkg;

    // converter and angle formats
    localparam int SAMPLE_BITS     = 12;
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int Z_FRAC          = 16;
    localparam int PRESCALE_BITS   = 8;
    localparam int ANGLE_W         = 15;

    // internal widths
    localparam int DW = SAMPLE_BITS + 1;
    localparam int XW = DW + PRESCALE_BITS + 3;
    localparam int ZW = Z_FRAC + 10;
    localparam int AW = ZW + 1;
    localparam int ROUND_SH = Z_FRAC - ANGLE_FRAC_BITS;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_X_REST = 1'b0;
    localparam logic REG_Y_REST = 1'b1;
    localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(2048);

    // angle constants in degrees times 2^Z_FRAC, OUT_WRAP in degrees times 2^ANGLE_FRAC_BITS
    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 <<< Z_FRAC);
    localparam logic signed [ZW-1:0] Z_HALF    = ZW'(180 <<< Z_FRAC);
    localparam logic signed [AW-1:0] A_HALF    = AW'(180 <<< Z_FRAC);
    localparam logic signed [AW-1:0] A_FULL    = AW'(360 <<< Z_FRAC);
    localparam logic signed [AW-1:0] A_ROUND   = AW'(1 <<< (ROUND_SH - 1));
    localparam logic signed [AW-1:0] OUT_WRAP  = AW'(360 <<< ANGLE_FRAC_BITS);

    // one vector in flight through the pipeline
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 bypass;
        logic                 pressed;
        logic                 released;
    } stage_t;

    // atan(2^-i) in degrees times 2^16, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q16(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:       v = ZW'(2949120);
            1:       v = ZW'(1740967);
            2:       v = ZW'(919879);
            3:       v = ZW'(466945);
            4:       v = ZW'(234379);
            5:       v = ZW'(117304);
            6:       v = ZW'(58666);
            7:       v = ZW'(29335);
            8:       v = ZW'(14668);
            9:       v = ZW'(7334);
            10:      v = ZW'(3667);
            11:      v = ZW'(1833);
            12:      v = ZW'(917);
            13:      v = ZW'(458);
            14:      v = ZW'(229);
            15:      v = ZW'(115);
            16:      v = ZW'(57);
            17:      v = ZW'(29);
            18:      v = ZW'(14);
            19:      v = ZW'(7);
            20:      v = ZW'(4);
            21:      v = ZW'(2);
            22:      v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/jda_front.sv]
// front stage: center subtraction, exact-axis cases, half-plane rotation, switch edges
`timescale 1ns / 1ps
`include "joystick_direction_angle_macros.svh"

module jda_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [jda_pkg::SAMPLE_BITS-1:0] x_rest,
    input  logic [jda_pkg::SAMPLE_BITS-1:0] y_rest,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [jda_pkg::SAMPLE_BITS-1:0] x_sample,
    input  logic [jda_pkg::SAMPLE_BITS-1:0] y_sample,
    input  logic                            switch_level,
    output logic                            front_valid,
    input  logic                            front_stall,
    output jda_pkg::stage_t                 front_data
);

    logic                             front_valid_reg;
    logic                             front_valid_next;
    jda_pkg::stage_t                  front_reg;
    jda_pkg::stage_t                  front_next;
    logic                             prev_switch_reg;
    logic                             prev_switch_next;
    logic                             hold;
    logic                             accept;
    logic signed [jda_pkg::DW-1:0]    dx;
    logic signed [jda_pkg::DW-1:0]    dy;
    logic signed [jda_pkg::DW-1:0]    ndx;
    logic signed [jda_pkg::DW-1:0]    ndy;

    // scale an offset by 2^PRESCALE_BITS into the cordic width
    function automatic logic signed [jda_pkg::XW-1:0] scale(
        input logic signed [jda_pkg::DW-1:0] v
    );
        return {{(jda_pkg::XW - jda_pkg::DW - jda_pkg::PRESCALE_BITS){v[jda_pkg::DW-1]}},
                v, {jda_pkg::PRESCALE_BITS{1'b0}}};
    endfunction

    // handshake
    assign hold         = front_valid_reg && front_stall;
    assign sample_stall = hold;
    assign accept       = sample_valid && !hold;
    assign front_valid  = front_valid_reg;
    assign front_data   = front_reg;

    // offsets from the rest position
    assign dx  = $signed({1'b0, x_sample}) - $signed({1'b0, x_rest});
    assign dy  = $signed({1'b0, y_sample}) - $signed({1'b0, y_rest});
    assign ndx = -dx;
    assign ndy = -dy;

    // starting vector and angle
    always_comb
    begin
        front_next.x        = scale(dx);
        front_next.y        = scale(dy);
        front_next.z        = '0;
        front_next.bypass   = 1'b0;
        front_next.pressed  = !prev_switch_reg && switch_level;
        front_next.released = prev_switch_reg && !switch_level;
        priority if (dy == '0)
        begin
            front_next.bypass = 1'b1;
            front_next.z      = dx[jda_pkg::DW-1] ? jda_pkg::Z_HALF : '0;
        end
        else if (dx == '0)
        begin
            front_next.bypass = 1'b1;
            front_next.z      = dy[jda_pkg::DW-1] ? -jda_pkg::Z_QUARTER : jda_pkg::Z_QUARTER;
        end
        else if (dx[jda_pkg::DW-1])
        begin
            // left half-plane: rotate into the right half first
            if (!dy[jda_pkg::DW-1])
            begin
                front_next.x = scale(dy);
                front_next.y = scale(ndx);
                front_next.z = jda_pkg::Z_QUARTER;
            end
            else
            begin
                front_next.x = scale(ndy);
                front_next.y = scale(dx);
                front_next.z = -jda_pkg::Z_QUARTER;
            end
        end
    end

    assign front_valid_next = hold ? front_valid_reg : sample_valid;
    assign prev_switch_next = accept ? switch_level : prev_switch_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
            prev_switch_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
            prev_switch_reg <= prev_switch_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_reg <= front_next;
        end
    end

    `JDA_ASSERT_NEXT(a_prev_switch_tracks, accept,
        prev_switch_reg == $past(switch_level),
        "switch history not updated on transfer")

endmodule

[rtl/jda_cordic.sv]
// cordic vectoring pipeline, one rotation per stage
`timescale 1ns / 1ps

module jda_cordic (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  jda_pkg::stage_t in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output jda_pkg::stage_t out_data
);

    localparam int N = jda_pkg::CORDIC_STEPS;

    jda_pkg::stage_t src_data [0:N-1];
    jda_pkg::stage_t stage_reg [0:N-1];
    logic [N-1:0]    src_valid;
    logic [N:0]      hold;
    logic [N-1:0]    stage_valid_reg;

    assign src_data[0]  = in_data;
    assign src_valid[0] = in_valid;
    assign hold[N]      = out_stall;
    assign in_stall     = hold[0];
    assign out_valid    = stage_valid_reg[N-1];
    assign out_data     = stage_reg[N-1];

    genvar k;
    for (k = 0; k < N; k++)
    begin : g_stage
        jda_pkg::stage_t                stage_next;
        logic signed [jda_pkg::XW-1:0]  xs;
        logic signed [jda_pkg::XW-1:0]  ys;

        // each stage takes the vector of the stage before it
        if (k > 0)
        begin : g_link
            assign src_data[k]  = stage_reg[k-1];
            assign src_valid[k] = stage_valid_reg[k-1];
        end

        assign hold[k] = stage_valid_reg[k] && hold[k+1];

        // shifted copies round toward minus infinity
        assign xs = $signed(src_data[k].x) >>> k;
        assign ys = $signed(src_data[k].y) >>> k;

        // one micro-rotation toward the x axis
        always_comb
        begin
            stage_next = src_data[k];
            if (!src_data[k].bypass)
            begin
                if (!src_data[k].y[jda_pkg::XW-1])
                begin
                    stage_next.x = src_data[k].x + ys;
                    stage_next.y = src_data[k].y - xs;
                    stage_next.z = src_data[k].z + jda_pkg::atan_q16(k);
                end
                else
                begin
                    stage_next.x = src_data[k].x - ys;
                    stage_next.y = src_data[k].y + xs;
                    stage_next.z = src_data[k].z - jda_pkg::atan_q16(k);
                end
            end
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_valid_reg[k] <= 1'b0;
            end
            else if (!hold[k])
            begin
                stage_valid_reg[k] <= src_valid[k];
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (!hold[k] && src_valid[k])
            begin
                stage_reg[k] <= stage_next;
            end
        end
    end

endmodule

[rtl/jda_finish.sv]
// output stage: reflect about 180 degrees, wrap, round and register the result
`timescale 1ns / 1ps
`include "joystick_direction_angle_macros.svh"

module jda_finish (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  jda_pkg::stage_t             in_data,
    output logic                        valid,
    input  logic                        stall,
    output logic [jda_pkg::ANGLE_W-1:0] angle_degrees,
    output logic                        pressed,
    output logic                        released
);

    logic                          out_valid_reg;
    logic [jda_pkg::ANGLE_W-1:0]   angle_reg;
    logic [jda_pkg::ANGLE_W-1:0]   angle_next;
    logic                          pressed_reg;
    logic                          released_reg;
    logic                          hold;
    logic                          load;
    logic signed [jda_pkg::AW-1:0] diff;
    logic signed [jda_pkg::AW-1:0] wrapped;
    logic signed [jda_pkg::AW-1:0] rounded;
    logic signed [jda_pkg::AW-1:0] final_angle;

    assign hold     = out_valid_reg && stall;
    assign in_stall = hold;
    assign load     = in_valid && !hold;

    // 180 minus the angle, wrapped once into one turn
    assign diff = jda_pkg::A_HALF - jda_pkg::AW'(in_data.z);
    always_comb
    begin
        priority if (diff[jda_pkg::AW-1])
        begin
            wrapped = diff + jda_pkg::A_FULL;
        end
        else if (diff >= jda_pkg::A_FULL)
        begin
            wrapped = diff - jda_pkg::A_FULL;
        end
        else
        begin
            wrapped = diff;
        end
    end

    // round half up to the output fraction, a full turn wraps to zero
    assign rounded     = (wrapped + jda_pkg::A_ROUND) >>> jda_pkg::ROUND_SH;
    assign final_angle = (rounded >= jda_pkg::OUT_WRAP) ? rounded - jda_pkg::OUT_WRAP : rounded;
    assign angle_next  = final_angle[jda_pkg::ANGLE_W-1:0];

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            angle_reg    <= angle_next;
            pressed_reg  <= in_data.pressed;
            released_reg <= in_data.released;
        end
    end

    assign valid         = out_valid_reg;
    assign angle_degrees = angle_reg;
    assign pressed       = pressed_reg;
    assign released      = released_reg;

    `JDA_ASSERT_ALWAYS(a_angle_in_turn, !out_valid_reg || ({1'b0, angle_reg} < jda_pkg::ANGLE_W'(jda_pkg::OUT_WRAP)), "angle outside one turn")

endmodule

[rtl/joystick_direction_angle.sv]
// top level of the joystick direction angle block
`timescale 1ns / 1ps
`include "joystick_direction_angle_macros.svh"

// Joystick direction angle. Each sample transfer (x_sample, y_sample,
// switch_level) yields one result transfer: angle_degrees is 180 minus
// atan2 of the centered Y and X offsets, in degrees times 64, in [0, 360),
// and pressed/released flag a rising or falling switch level relative to the
// previous sample. The block takes one sample every cycle while sample_stall
// is low. A sample passes through 18 register stages: one input stage
// (centering and half-plane rotation), 16 cordic rotation stages and one
// output stage (wrap and rounding). Stages with a bubble keep filling while
// the result is stalled. The X rest position (address 0) and the Y rest
// position (address 4) reset to 2048 and should be written only while no
// sample is in flight.
module joystick_direction_angle (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jda_pkg::ADDR_W-1:0]      paddr,
    input  logic [jda_pkg::DATA_W-1:0]      pwdata,
    output logic [jda_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [jda_pkg::SAMPLE_BITS-1:0] x_sample,
    input  logic [jda_pkg::SAMPLE_BITS-1:0] y_sample,
    input  logic                            switch_level,
    output logic                            angle_valid,
    input  logic                            angle_stall,
    output logic [jda_pkg::ANGLE_W-1:0]     angle_degrees,
    output logic                            pressed,
    output logic                            released
);

    logic [jda_pkg::SAMPLE_BITS-1:0] x_rest_reg;
    logic [jda_pkg::SAMPLE_BITS-1:0] y_rest_reg;
    logic                            cfg_write;
    logic                            reg_sel;
    logic                            front_valid;
    logic                            front_stall;
    jda_pkg::stage_t                 front_data;
    logic                            cordic_valid;
    logic                            cordic_stall;
    jda_pkg::stage_t                 cordic_data;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_rest_reg <= jda_pkg::CENTER_RESET;
            y_rest_reg <= jda_pkg::CENTER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                jda_pkg::REG_X_REST: x_rest_reg <= pwdata[jda_pkg::SAMPLE_BITS-1:0];
                jda_pkg::REG_Y_REST: y_rest_reg <= pwdata[jda_pkg::SAMPLE_BITS-1:0];
                default:             x_rest_reg <= x_rest_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_sel)
            jda_pkg::REG_X_REST:
                prdata = {{(jda_pkg::DATA_W - jda_pkg::SAMPLE_BITS){1'b0}}, x_rest_reg};
            jda_pkg::REG_Y_REST:
                prdata = {{(jda_pkg::DATA_W - jda_pkg::SAMPLE_BITS){1'b0}}, y_rest_reg};
            default:
                prdata = '0;
        endcase
    end

    // input stage
    jda_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .x_rest       (x_rest_reg),
        .y_rest       (y_rest_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .x_sample     (x_sample),
        .y_sample     (y_sample),
        .switch_level (switch_level),
        .front_valid  (front_valid),
        .front_stall  (front_stall),
        .front_data   (front_data)
    );

    // rotation pipeline
    jda_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_stall  (front_stall),
        .in_data   (front_data),
        .out_valid (cordic_valid),
        .out_stall (cordic_stall),
        .out_data  (cordic_data)
    );

    // output stage
    jda_finish u_finish (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (cordic_valid),
        .in_stall      (cordic_stall),
        .in_data       (cordic_data),
        .valid         (angle_valid),
        .stall         (angle_stall),
        .angle_degrees (angle_degrees),
        .pressed       (pressed),
        .released      (released)
    );

    `JDA_ASSERT_ALWAYS(a_edges_exclusive,
        !(angle_valid && pressed && released),
        "pressed and released in one result")

endmodule
